// ===== src/state_variable_filter_q31_unit_defines.svh =====
// Assertion macros for the state-variable filter unit.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef STATE_VARIABLE_FILTER_Q31_UNIT_DEFINES_SVH
`define STATE_VARIABLE_FILTER_Q31_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// prop must hold at every clock edge outside reset
`define SVF_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// cond must never be true outside reset
`define SVF_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define SVF_ASSERT(lbl, clk, rstn, prop, msg)
`define SVF_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

// ===== src/svf_pkg.sv =====
// Shared types, codes and Q31 helpers for the state-variable filter unit.
// No dependencies; imported by the controller, datapath and top level.
package svf_pkg;

  localparam int SampleW = 32;
  localparam int CoeffW  = 31;
  localparam int IdxW    = 3;

  localparam logic signed [SampleW-1:0] MaxQ31 = 32'sh7FFF_FFFF;
  localparam logic signed [SampleW-1:0] MinQ31 = 32'sh8000_0000;

  // register indexes
  localparam logic [IdxW-1:0] RegCutoff   = 3'd0;
  localparam logic [IdxW-1:0] RegRecipQ   = 3'd1;
  localparam logic [IdxW-1:0] RegLowMix   = 3'd2;
  localparam logic [IdxW-1:0] RegHighMix  = 3'd3;
  localparam logic [IdxW-1:0] RegBandMix  = 3'd4;
  localparam logic [IdxW-1:0] RegNotchMix = 3'd5;
  localparam logic [IdxW-1:0] RegMode     = 3'd6;

  // output modes
  localparam logic [1:0] ModeMix  = 2'd0;
  localparam logic [1:0] ModeLow  = 2'd1;
  localparam logic [1:0] ModeBand = 2'd2;
  localparam logic [1:0] ModeHigh = 2'd3;

  // normalizer: shift steps of 16, 8, 4, 2, 1
  localparam logic [2:0] NormSteps = 3'd5;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_CUT_BAND,
    MUL_RQ_BAND,
    MUL_CUT_HIGH,
    MUL_LOW_MIX,
    MUL_HIGH_MIX,
    MUL_BAND_MIX,
    MUL_NOTCH_MIX
  } mul_sel_e;

  typedef enum logic [3:0] {
    ALU_NOP,
    ALU_LOAD_X,
    ALU_LOW,
    ALU_DAMP,
    ALU_HIGH,
    ALU_NOTCH,
    ALU_BAND,
    ALU_ACC_FIRST,
    ALU_ACC,
    ALU_Y_FIRST,
    ALU_Y_SUM,
    ALU_Y_SEL
  } alu_op_e;

  typedef struct packed {
    mul_sel_e mul_sel;
    alu_op_e  alu_op;
  } svf_cmd_t;

  typedef struct packed {
    logic norm_busy;
    logic mix_mode;
  } svf_status_t;

  // saturating 32-bit add or subtract
  function automatic logic signed [SampleW-1:0] sat_add(
    input logic signed [SampleW-1:0] a,
    input logic signed [SampleW-1:0] b,
    input logic                      sub
  );
    logic signed [SampleW:0] s;
    s = sub ? (33'(a) - 33'(b)) : (33'(a) + 33'(b));
    if (s[SampleW] != s[SampleW-1]) begin
      return s[SampleW] ? MinQ31 : MaxQ31;
    end
    return s[SampleW-1:0];
  endfunction

  // Q31 product scaling: floor(p / 2^31), saturated (only -1 * -1 overflows)
  function automatic logic signed [SampleW-1:0] q31_scale(
    input logic signed [2*SampleW-1:0] p
  );
    if (!p[2*SampleW-1] && p[2*SampleW-2]) begin
      return MaxQ31;
    end
    return p[2*SampleW-2:SampleW-1];
  endfunction

endpackage

// ===== src/svf_in_if.sv =====
// Input sample channel: valid/ready handshake with one Q31 sample per beat.
// No dependencies.
interface svf_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

// ===== src/svf_out_if.sv =====
// Output sample channel: valid/ready handshake with one Q31 sample per beat.
// No dependencies.
interface svf_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

// ===== src/svf_datapath.sv =====
// Datapath: config registers, 1/Q normalizer, filter state, one shared Q31
// multiplier and one saturating adder. Depends on svf_pkg.
module svf_datapath import svf_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [IdxW-1:0]           cfg_idx_i,
  input  logic [SampleW-1:0]        cfg_wdata_i,
  input  logic signed [SampleW-1:0] sample_i,
  input  svf_cmd_t                  cmd_i,
  output svf_status_t               status_o,
  output logic signed [SampleW-1:0] y_o
);

  logic [CoeffW-1:0]         cutoff_q, cutoff_d;
  logic signed [SampleW-1:0] low_mix_q, low_mix_d;
  logic signed [SampleW-1:0] high_mix_q, high_mix_d;
  logic signed [SampleW-1:0] band_mix_q, band_mix_d;
  logic signed [SampleW-1:0] notch_mix_q, notch_mix_d;
  logic [1:0]                mode_q, mode_d;

  logic [CoeffW-1:0] rqn_q, rqn_d;
  logic [4:0]        rqs_q, rqs_d;
  logic [2:0]        nstep_q, nstep_d;
  logic [4:0]        norm_k;
  logic [CoeffW-1:0] norm_mask;

  logic signed [SampleW-1:0]   low_q, low_d, band_q, band_d, high_q, high_d;
  logic signed [SampleW-1:0]   notch_q, notch_d, t_q, t_d, acc_q, acc_d;
  logic signed [SampleW-1:0]   y_q, y_d, x_q, x_d;
  logic signed [2*SampleW-1:0] prod_q;
  logic signed [SampleW-1:0]   mul_a, mul_b;

  logic signed [SampleW-1:0] qp, damp, half, add_a, add_b, sum;
  logic                      add_sub;

  // normalizer: binary search for leading zero bits, one step a cycle
  assign norm_k    = 5'd16 >> nstep_q;
  assign norm_mask = ~({CoeffW{1'b1}} >> norm_k);

  always_comb begin
    cutoff_d    = cutoff_q;
    low_mix_d   = low_mix_q;
    high_mix_d  = high_mix_q;
    band_mix_d  = band_mix_q;
    notch_mix_d = notch_mix_q;
    mode_d      = mode_q;
    rqn_d       = rqn_q;
    rqs_d       = rqs_q;
    nstep_d     = nstep_q;
    if (nstep_q != NormSteps) begin
      nstep_d = nstep_q + 3'd1;
      if (rqn_q != '0 && (rqn_q & norm_mask) == '0) begin
        rqn_d = rqn_q << norm_k;
        rqs_d = rqs_q + norm_k;
      end
    end
    if (cfg_we_i) begin
      case (cfg_idx_i)
        RegCutoff:   cutoff_d    = cfg_wdata_i[CoeffW-1:0];
        RegRecipQ: begin
          rqn_d   = cfg_wdata_i[CoeffW-1:0];
          rqs_d   = '0;
          nstep_d = '0;
        end
        RegLowMix:   low_mix_d   = cfg_wdata_i;
        RegHighMix:  high_mix_d  = cfg_wdata_i;
        RegBandMix:  band_mix_d  = cfg_wdata_i;
        RegNotchMix: notch_mix_d = cfg_wdata_i;
        RegMode:     mode_d      = cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.mul_sel)
      MUL_CUT_BAND: begin
        mul_a = {1'b0, cutoff_q};
        mul_b = band_q;
      end
      MUL_RQ_BAND: begin
        mul_a = {1'b0, rqn_q};
        mul_b = band_q;
      end
      MUL_CUT_HIGH: begin
        mul_a = {1'b0, cutoff_q};
        mul_b = high_q;
      end
      MUL_LOW_MIX: begin
        mul_a = low_q;
        mul_b = low_mix_q;
      end
      MUL_HIGH_MIX: begin
        mul_a = high_q;
        mul_b = high_mix_q;
      end
      MUL_BAND_MIX: begin
        mul_a = band_q;
        mul_b = band_mix_q;
      end
      MUL_NOTCH_MIX: begin
        mul_a = notch_q;
        mul_b = notch_mix_q;
      end
      default: ;
    endcase
  end

  assign qp   = q31_scale(prod_q);
  assign damp = qp >>> rqs_q;
  assign half = acc_q >>> 1;

  // shared saturating adder
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    case (cmd_i.alu_op)
      ALU_LOW: begin
        add_a = low_q;
        add_b = qp;
      end
      ALU_DAMP: begin
        add_a   = x_q;
        add_b   = damp;
        add_sub = 1'b1;
      end
      ALU_HIGH: begin
        add_a   = t_q;
        add_b   = low_q;
        add_sub = 1'b1;
      end
      ALU_NOTCH: begin
        add_a = low_q;
        add_b = high_q;
      end
      ALU_BAND: begin
        add_a = band_q;
        add_b = qp;
      end
      ALU_ACC_FIRST: add_a = qp;
      ALU_ACC: begin
        add_a = acc_q;
        add_b = qp;
      end
      ALU_Y_FIRST: add_a = half;
      ALU_Y_SUM: begin
        add_a = y_q;
        add_b = half;
      end
      default: ;
    endcase
  end

  assign sum = sat_add(add_a, add_b, add_sub);

  always_comb begin
    low_d   = low_q;
    band_d  = band_q;
    high_d  = high_q;
    notch_d = notch_q;
    t_d     = t_q;
    acc_d   = acc_q;
    y_d     = y_q;
    x_d     = x_q;
    case (cmd_i.alu_op)
      ALU_LOAD_X:    x_d     = sample_i;
      ALU_LOW:       low_d   = sum;
      ALU_DAMP:      t_d     = sum;
      ALU_HIGH:      high_d  = sum;
      ALU_NOTCH:     notch_d = sum;
      ALU_BAND:      band_d  = sum;
      ALU_ACC_FIRST,
      ALU_ACC:       acc_d   = sum;
      ALU_Y_FIRST,
      ALU_Y_SUM:     y_d     = sum;
      ALU_Y_SEL: begin
        case (mode_q)
          ModeLow:  y_d = low_q;
          ModeBand: y_d = band_q;
          default:  y_d = high_q;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q    <= '0;
      low_mix_q   <= '0;
      high_mix_q  <= '0;
      band_mix_q  <= '0;
      notch_mix_q <= '0;
      mode_q      <= ModeMix;
      rqn_q       <= '0;
      rqs_q       <= '0;
      nstep_q     <= NormSteps;
      low_q       <= '0;
      band_q      <= '0;
      high_q      <= '0;
    end else begin
      cutoff_q    <= cutoff_d;
      low_mix_q   <= low_mix_d;
      high_mix_q  <= high_mix_d;
      band_mix_q  <= band_mix_d;
      notch_mix_q <= notch_mix_d;
      mode_q      <= mode_d;
      rqn_q       <= rqn_d;
      rqs_q       <= rqs_d;
      nstep_q     <= nstep_d;
      low_q       <= low_d;
      band_q      <= band_d;
      high_q      <= high_d;
    end
  end

  // scratch registers, no reset
  always_ff @(posedge clk_i) begin
    notch_q <= notch_d;
    t_q     <= t_d;
    acc_q   <= acc_d;
    y_q     <= y_d;
    x_q     <= x_d;
    if (cmd_i.mul_sel != MUL_NONE) begin
      prod_q <= 64'(mul_a) * 64'(mul_b);
    end
  end

  assign status_o.norm_busy = (nstep_q != NormSteps);
  assign status_o.mix_mode  = (mode_q == ModeMix);
  assign y_o                = y_q;

endmodule

// ===== src/svf_ctrl.sv =====
// Controller: sequences the frame and mix steps of one sample through the
// datapath and runs the handshakes. Depends on svf_pkg and the defines header.
`include "state_variable_filter_q31_unit_defines.svh"

module svf_ctrl import svf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  svf_status_t status_i,
  output svf_cmd_t    cmd_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_F0   = 4'd1;
  localparam logic [3:0] S_F1   = 4'd2;
  localparam logic [3:0] S_F2   = 4'd3;
  localparam logic [3:0] S_F3   = 4'd4;
  localparam logic [3:0] S_F4   = 4'd5;
  localparam logic [3:0] S_F5   = 4'd6;
  localparam logic [3:0] S_M0   = 4'd7;
  localparam logic [3:0] S_M1   = 4'd8;
  localparam logic [3:0] S_M2   = 4'd9;
  localparam logic [3:0] S_M3   = 4'd10;
  localparam logic [3:0] S_M4   = 4'd11;
  localparam logic [3:0] S_SEL  = 4'd12;
  localparam logic [3:0] S_OUT  = 4'd13;

  logic [3:0] state_q, state_d;
  logic       frame_q, frame_d;  // second frame of the oversampled mix

  assign in_ready_o  = (state_q == S_IDLE) && !status_i.norm_busy;
  assign out_valid_o = (state_q == S_OUT);

  always_comb begin
    state_d       = state_q;
    frame_d       = frame_q;
    cmd_o.mul_sel = MUL_NONE;
    cmd_o.alu_op  = ALU_NOP;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.alu_op = ALU_LOAD_X;
          frame_d      = 1'b0;
          state_d      = S_F0;
        end
      end
      S_F0: begin
        cmd_o.mul_sel = MUL_CUT_BAND;
        state_d       = S_F1;
      end
      S_F1: begin
        cmd_o.mul_sel = MUL_RQ_BAND;
        cmd_o.alu_op  = ALU_LOW;
        state_d       = S_F2;
      end
      S_F2: begin
        cmd_o.alu_op = ALU_DAMP;
        state_d      = S_F3;
      end
      S_F3: begin
        cmd_o.alu_op = ALU_HIGH;
        state_d      = S_F4;
      end
      S_F4: begin
        cmd_o.mul_sel = MUL_CUT_HIGH;
        cmd_o.alu_op  = ALU_NOTCH;
        state_d       = S_F5;
      end
      S_F5: begin
        cmd_o.mul_sel = MUL_LOW_MIX;
        cmd_o.alu_op  = ALU_BAND;
        state_d       = status_i.mix_mode ? S_M0 : S_SEL;
      end
      S_M0: begin
        cmd_o.mul_sel = MUL_HIGH_MIX;
        cmd_o.alu_op  = ALU_ACC_FIRST;
        state_d       = S_M1;
      end
      S_M1: begin
        cmd_o.mul_sel = MUL_BAND_MIX;
        cmd_o.alu_op  = ALU_ACC;
        state_d       = S_M2;
      end
      S_M2: begin
        cmd_o.mul_sel = MUL_NOTCH_MIX;
        cmd_o.alu_op  = ALU_ACC;
        state_d       = S_M3;
      end
      S_M3: begin
        cmd_o.alu_op = ALU_ACC;
        state_d      = S_M4;
      end
      S_M4: begin
        if (frame_q) begin
          cmd_o.alu_op = ALU_Y_SUM;
          state_d      = S_OUT;
        end else begin
          cmd_o.alu_op = ALU_Y_FIRST;
          frame_d      = 1'b1;
          state_d      = S_F0;
        end
      end
      S_SEL: begin
        cmd_o.alu_op = ALU_Y_SEL;
        state_d      = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      frame_q <= 1'b0;
    end else begin
      state_q <= state_d;
      frame_q <= frame_d;
    end
  end

  `SVF_ASSERT(a_one_in_flight, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> !in_ready_o, "second beat taken while busy")
  `SVF_ASSERT(a_back_to_idle, clk_i, rst_ni, (out_valid_o && out_ready_i) |=> (in_ready_o || status_i.norm_busy), "not ready after result beat")
  `SVF_ASSERT(a_mix_ends, clk_i, rst_ni, (state_q == S_M4 && frame_q) |=> out_valid_o, "mix result not presented")
  `SVF_ASSERT(a_out_source, clk_i, rst_ni, $rose(out_valid_o) |-> $past(state_q == S_M4 || state_q == S_SEL), "result shown without a final step")

endmodule

// ===== src/state_variable_filter_q31_unit.sv =====
// Top level of the Q31 state-variable filter: controller plus datapath.
// Depends on svf_pkg, svf_in_if, svf_out_if, svf_ctrl and svf_datapath.

// Takes one Q31 sample per input beat and returns one filtered Q31 sample per
// output beat, one sample in flight at a time. The work runs on a single
// 32x32 multiplier with a registered product and one saturating adder: a
// lowpass, bandpass or highpass sample takes one filter frame and a select
// step, the oversampled mix two filter frames, each with a four-term weighted
// mix; taking the sample and presenting the result are steps of their own.
// A write to recip_q starts a normalization of 1/Q; no sample is taken until
// it finishes. The user must write registers through cfg_we_i, cfg_idx_i and
// cfg_wdata_i only while no sample is in flight; the block does not check it.
module state_variable_filter_q31_unit import svf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  svf_in_if.sink             in_ch,
  svf_out_if.source          out_ch,
  input  logic               cfg_we_i,
  input  logic [IdxW-1:0]    cfg_idx_i,
  input  logic [SampleW-1:0] cfg_wdata_i
);

  svf_cmd_t    cmd;
  svf_status_t status;
  logic        in_ready;
  logic        out_valid;

  svf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_ch.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  svf_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sample_i    (in_ch.sample_in),
    .cmd_i       (cmd),
    .status_o    (status),
    .y_o         (out_ch.sample_out)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

endmodule
